>>> src/rtty_telemetry_transmitter_crc16_defines.svh
// assertion macros for the rtty telemetry transmitter
// used by the top level only; expects clk and rst_n in scope
`ifndef RTTY_TELEMETRY_TRANSMITTER_CRC16_DEFINES_SVH
`define RTTY_TELEMETRY_TRANSMITTER_CRC16_DEFINES_SVH

// same-cycle implication
`define RTTX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTTX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rttx_pkg.sv
// shared types, constants and helper functions for the rtty transmitter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rttx_pkg;

    // frame geometry
    localparam int DATA_BITS   = 7;
    localparam int FRAME_LEN   = DATA_BITS + 2;
    localparam int BIT_IDX_W   = $clog2(FRAME_LEN);
    localparam int TRAILER_LEN = 7;
    localparam int FRAME_IDX_W = $clog2(TRAILER_LEN);

    // command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // baud register
    localparam int          BAUD_W     = 10;
    localparam logic [9:0]  BAUD_RESET = 10'd50;
    localparam logic [9:0]  BAUD_100   = 10'd100;
    localparam logic [9:0]  BAUD_150   = 10'd150;
    localparam logic [9:0]  BAUD_200   = 10'd200;
    localparam logic [9:0]  BAUD_300   = 10'd300;

    // symbol hold times in microseconds
    localparam int          DUR_W       = 15;
    localparam logic [14:0] DUR_100     = 15'd10300;
    localparam logic [14:0] DUR_150     = 15'd6830;
    localparam logic [14:0] DUR_200     = 15'd5050;
    localparam logic [14:0] DUR_300     = 15'd3400;
    localparam logic [14:0] DUR_DEFAULT = 15'(10000 + 10600);

    // crc
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A_OFS  = 8'h37;

    // trailer frame positions
    localparam logic [FRAME_IDX_W-1:0] FR_STAR = FRAME_IDX_W'(0);
    localparam logic [FRAME_IDX_W-1:0] FR_HEX3 = FRAME_IDX_W'(1);
    localparam logic [FRAME_IDX_W-1:0] FR_HEX2 = FRAME_IDX_W'(2);
    localparam logic [FRAME_IDX_W-1:0] FR_HEX1 = FRAME_IDX_W'(3);
    localparam logic [FRAME_IDX_W-1:0] FR_HEX0 = FRAME_IDX_W'(4);
    localparam logic [FRAME_IDX_W-1:0] FR_CR   = FRAME_IDX_W'(5);
    localparam logic [FRAME_IDX_W-1:0] FR_LF   = FRAME_IDX_W'(TRAILER_LEN - 1);

    typedef enum logic {
        OP_SEND   = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // input word
    typedef struct packed {
        op_t        operation;
        logic [7:0] character;
    } in_word_t;

    // output word, one per symbol
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] duration_us;
        logic             last;
    } out_word_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t              op;
        logic [7:0]       character;
        logic [15:0]      crc;
        logic [DUR_W-1:0] dur;
    } cmd_t;

    // back-end status
    typedef struct packed {
        logic busy;
        logic pop;
    } bk_status_t;

    function automatic logic [DUR_W-1:0] symbol_time(input logic [BAUD_W-1:0] baud);
        logic [DUR_W-1:0] d;
        case (baud)
            BAUD_200: d = DUR_200;
            BAUD_300: d = DUR_300;
            BAUD_150: d = DUR_150;
            BAUD_100: d = DUR_100;
            default:  d = DUR_DEFAULT;
        endcase
        return d;
    endfunction

    // msb-first crc-16 update over one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10)
            c = CH_ZERO + 8'(n);
        else
            c = CH_A_OFS + 8'(n);
        return c;
    endfunction

    // character of a trailer frame
    function automatic logic [7:0] trailer_char(input logic [FRAME_IDX_W-1:0] idx,
                                                input logic [15:0] crc);
        logic [7:0] c;
        case (idx)
            FR_STAR: c = CH_STAR;
            FR_HEX3: c = hex_char(crc[15:12]);
            FR_HEX2: c = hex_char(crc[11:8]);
            FR_HEX1: c = hex_char(crc[7:4]);
            FR_HEX0: c = hex_char(crc[3:0]);
            FR_CR:   c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/rtty_telemetry_transmitter_crc16.sv
// Async serial telemetry transmitter with running CRC-16. Each send word gives one frame of
// DATA_BITS+2 output words (start, data lsb first, stop), one per clock when out_ready is
// high. A finish word gives seven frames ('*', four hex CRC digits, CR, LF), and the CRC
// is reloaded when that word is accepted. The rate is set by the back-end sequencer, which
// emits one symbol per cycle into a single output register unless out_ready stalls it; a
// two-entry command queue lets the front end accept the next word while a frame is being sent.
// Baud writes take effect from the next accepted word.
// depends on rttx_pkg, rttx_front, rttx_fifo, rttx_back and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "rtty_telemetry_transmitter_crc16_defines.svh"

module rtty_telemetry_transmitter_crc16 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rttx_pkg::BAUD_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  rttx_pkg::in_word_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output rttx_pkg::out_word_t         out_data
);

    logic                 q_push;
    logic                 q_not_full;
    logic                 q_valid;
    logic                 q_pop;
    rttx_pkg::cmd_t       push_cmd;
    rttx_pkg::cmd_t       head_cmd;
    rttx_pkg::bk_status_t bk_stat;

    // front end
    rttx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_ready   (q_not_full),
        .q_push    (q_push),
        .q_data    (push_cmd)
    );

    // command queue
    rttx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (head_cmd)
    );

    // symbol sequencer
    rttx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (head_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .status    (bk_stat)
    );

    // checks
    `RTTX_ASSERT_IMP(a_pop_nonempty, bk_stat.pop, q_valid, "back popped an empty queue")
    `RTTX_ASSERT_NEXT(a_idle_picks_up, !bk_stat.busy && q_valid, bk_stat.busy, "head not taken")
    `RTTX_ASSERT_IMP(a_done_on_last, $fell(bk_stat.busy), out_valid && out_data.last, "early idle")

endmodule

`default_nettype wire

>>> src/rttx_front.sv
// front end: accepts input words, holds baud and running crc, issues commands
// depends on rttx_pkg
`timescale 1ns / 1ps
`default_nettype none

module rttx_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rttx_pkg::BAUD_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rttx_pkg::in_word_t            in_data,
    input  logic                          q_ready,
    output logic                          q_push,
    output rttx_pkg::cmd_t                q_data
);

    logic [rttx_pkg::BAUD_W-1:0] baud_reg;
    logic [rttx_pkg::BAUD_W-1:0] baud_next;
    logic [15:0]                 crc_reg;
    logic [15:0]                 crc_next;

    // accept whenever the queue has room
    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    // build the command word
    always_comb
    begin
        q_data.op        = in_data.operation;
        q_data.character = in_data.character;
        q_data.crc       = crc_reg;
        q_data.dur       = rttx_pkg::symbol_time(baud_reg);
    end

    // next register values
    always_comb
    begin
        baud_next = cfg_we ? cfg_wdata : baud_reg;
        crc_next  = crc_reg;
        if (q_push)
        begin
            if (in_data.operation == rttx_pkg::OP_FINISH)
                crc_next = rttx_pkg::CRC_INIT;
            else if (in_data.character != rttx_pkg::CH_DOLLAR)
                crc_next = rttx_pkg::crc_fold(crc_reg, in_data.character);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baud_reg <= rttx_pkg::BAUD_RESET;
            crc_reg  <= rttx_pkg::CRC_INIT;
        end
        else
        begin
            baud_reg <= baud_next;
            crc_reg  <= crc_next;
        end
    end

endmodule

`default_nettype wire

>>> src/rttx_fifo.sv
// small command queue between front and back
// depends on rttx_pkg
`timescale 1ns / 1ps
`default_nettype none

module rttx_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rttx_pkg::cmd_t  push_data,
    output logic            not_full,
    input  logic            pop,
    output logic            not_empty,
    output rttx_pkg::cmd_t  pop_data
);

    rttx_pkg::cmd_t                 entry_reg [rttx_pkg::Q_DEPTH];
    logic [rttx_pkg::Q_PTR_W-1:0]   wr_ptr_reg;
    logic [rttx_pkg::Q_PTR_W-1:0]   wr_ptr_next;
    logic [rttx_pkg::Q_PTR_W-1:0]   rd_ptr_reg;
    logic [rttx_pkg::Q_PTR_W-1:0]   rd_ptr_next;
    logic [rttx_pkg::Q_PTR_W:0]     count_reg;
    logic [rttx_pkg::Q_PTR_W:0]     count_next;
    logic                           do_push;
    logic                           do_pop;

    localparam logic [rttx_pkg::Q_PTR_W:0] FULL_COUNT = (rttx_pkg::Q_PTR_W + 1)'(rttx_pkg::Q_DEPTH);
    localparam logic [rttx_pkg::Q_PTR_W-1:0] LAST_PTR = rttx_pkg::Q_PTR_W'(rttx_pkg::Q_DEPTH - 1);

    assign not_full  = (count_reg != FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + (rttx_pkg::Q_PTR_W + 1)'(do_push)
                               - (rttx_pkg::Q_PTR_W + 1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> src/rttx_back.sv
// back end: steps through the frames of one command, one symbol per cycle unless out_ready stalls it
// depends on rttx_pkg
`timescale 1ns / 1ps
`default_nettype none

module rttx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  rttx_pkg::cmd_t       q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rttx_pkg::out_word_t  out_data,
    output rttx_pkg::bk_status_t status
);

    localparam logic [rttx_pkg::BIT_IDX_W-1:0] STOP_IDX =
        rttx_pkg::BIT_IDX_W'(rttx_pkg::FRAME_LEN - 1);

    logic                                 busy_reg;
    logic                                 busy_next;
    rttx_pkg::cmd_t                       cmd_reg;
    rttx_pkg::cmd_t                       cmd_next;
    logic [rttx_pkg::FRAME_IDX_W-1:0]     frame_reg;
    logic [rttx_pkg::FRAME_IDX_W-1:0]     frame_next;
    logic [rttx_pkg::BIT_IDX_W-1:0]       bit_reg;
    logic [rttx_pkg::BIT_IDX_W-1:0]       bit_next;
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    rttx_pkg::out_word_t                  out_data_reg;
    rttx_pkg::out_word_t                  out_data_next;

    logic                                 advance;
    logic [7:0]                           cur_char;
    logic [2:0]                           data_sel;
    rttx_pkg::out_word_t                  sym;

    assign advance   = busy_reg && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign status    = '{busy: busy_reg, pop: q_pop};

    // current symbol
    always_comb
    begin
        if (cmd_reg.op == rttx_pkg::OP_SEND)
            cur_char = cmd_reg.character;
        else
            cur_char = rttx_pkg::trailer_char(frame_reg, cmd_reg.crc);
        data_sel = 3'(bit_reg - 1'b1);
        if (bit_reg == '0)
            sym.level = 1'b0;
        else if (bit_reg == STOP_IDX)
            sym.level = 1'b1;
        else
            sym.level = cur_char[data_sel];
        sym.duration_us = cmd_reg.dur;
        sym.last = (bit_reg == STOP_IDX) &&
                   ((cmd_reg.op == rttx_pkg::OP_SEND) || (frame_reg == rttx_pkg::FR_LF));
    end

    // sequencer
    always_comb
    begin
        busy_next      = busy_reg;
        cmd_next       = cmd_reg;
        frame_next     = frame_reg;
        bit_next       = bit_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sym;
            if (sym.last)
            begin
                // chain straight into the next queued command
                busy_next  = q_valid;
                q_pop      = q_valid;
                cmd_next   = q_data;
                frame_next = '0;
                bit_next   = '0;
            end
            else if (bit_reg == STOP_IDX)
            begin
                bit_next   = '0;
                frame_next = frame_reg + 1'b1;
            end
            else
            begin
                bit_next = bit_reg + 1'b1;
            end
        end
        else if (!busy_reg && q_valid)
        begin
            busy_next  = 1'b1;
            q_pop      = 1'b1;
            cmd_next   = q_data;
            frame_next = '0;
            bit_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            frame_reg     <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            frame_reg     <= frame_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

>>> dv/tb_rtty_telemetry_transmitter_crc16.sv
// self-checking testbench for the rtty telemetry transmitter with running crc-16
// depends on rttx_pkg and the rtty_telemetry_transmitter_crc16 top level
`timescale 1ns / 1ps

module tb_rtty_telemetry_transmitter_crc16;
    import rttx_pkg::*;

    localparam int  CLK_HALF      = 10;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  CYCLE_LIMIT   = 1_500_000;
    localparam int  RAND_PHASES   = 6;
    localparam int  PHASE_WORDS   = 32;
    localparam int  PLAN_LEN      = 19;

    // one directed step: optional baud write, then one input word
    typedef struct packed {
        logic              wr;
        logic [BAUD_W-1:0] baud;
        op_t               op;
        logic [7:0]        ch;
        logic [DUR_W-1:0]  dur;   // nonzero: expected hold time given directly; zero: taken from the baud
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // finish straight after reset: trailer carries the initial crc
        '{1'b0, 10'd0,     OP_FINISH, 8'h00,     DUR_DEFAULT},
        '{1'b0, 10'd0,     OP_SEND,   8'h00,     DUR_DEFAULT},
        '{1'b0, 10'd0,     OP_SEND,   8'hFF,     15'd0},
        '{1'b0, 10'd0,     OP_SEND,   CH_DOLLAR, 15'd0},
        '{1'b0, 10'd0,     OP_SEND,   8'h7F,     15'd0},
        '{1'b0, 10'd0,     OP_SEND,   8'h80,     15'd0},
        '{1'b0, 10'd0,     OP_FINISH, 8'hFF,     15'd0},
        '{1'b1, BAUD_100,  OP_SEND,   8'h55,     DUR_100},
        '{1'b1, BAUD_150,  OP_SEND,   8'hAA,     DUR_150},
        '{1'b1, BAUD_200,  OP_SEND,   8'h01,     DUR_200},
        '{1'b1, BAUD_300,  OP_SEND,   8'hFE,     DUR_300},
        '{1'b0, 10'd0,     OP_FINISH, 8'h00,     15'd0},
        '{1'b1, 10'd0,     OP_SEND,   8'h40,     DUR_DEFAULT},
        '{1'b1, 10'd1023,  OP_SEND,   CH_DOLLAR, DUR_DEFAULT},
        '{1'b0, 10'd0,     OP_FINISH, 8'h00,     15'd0},
        // low seven bits look like a dollar sign but the byte is folded
        '{1'b1, 10'd301,   OP_SEND,   8'hA4,     DUR_DEFAULT},
        '{1'b1, 10'd99,    OP_SEND,   8'h0D,     DUR_DEFAULT},
        '{1'b0, 10'd0,     OP_FINISH, 8'h00,     15'd0},
        // second finish in a row sends the reloaded crc
        '{1'b0, 10'd0,     OP_FINISH, 8'h00,     15'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [BAUD_W-1:0]   cfg_wdata;
    logic                in_valid;
    logic                in_ready;
    in_word_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_word_t           out_data;

    // predictor state
    logic [BAUD_W-1:0]   baud_q;
    logic [15:0]         crc_q;
    out_word_t           pending_symbols [$];
    int                  mismatch_cnt;
    int                  cycle_cnt;
    int                  ready_hold;

    rtty_telemetry_transmitter_crc16 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 24);
    endfunction

    // symbol hold time for a baud selector
    function automatic logic [DUR_W-1:0] hold_time(input logic [BAUD_W-1:0] b);
        if (b == BAUD_100)
            return DUR_100;
        if (b == BAUD_150)
            return DUR_150;
        if (b == BAUD_200)
            return DUR_200;
        if (b == BAUD_300)
            return DUR_300;
        return DUR_DEFAULT;
    endfunction

    // crc-16 update, one message bit at a time, msb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ CRC_POLY;
        end
        return r;
    endfunction

    // uppercase ascii hex digit
    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n < 4'd10)
            return CH_ZERO + {4'h0, n};
        return 8'h41 + {4'h0, n} - 8'd10;
    endfunction

    // queue the symbols of one frame: start, data lsb first, stop
    task automatic queue_frame(input logic [7:0] ch, input logic [DUR_W-1:0] dur,
                               input logic ends_word);
        out_word_t s;
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            s.duration_us = dur;
            s.last        = 1'b0;
            if (i == 0)
                s.level = 1'b0;
            else if (i == FRAME_LEN - 1)
            begin
                s.level = 1'b1;
                s.last  = ends_word;
            end
            else
                s.level = ch[i-1];
            pending_symbols.push_back(s);
        end
    endtask

    // expected symbols of one input word, advancing the running crc
    task automatic predict_word(input in_word_t w, input logic [DUR_W-1:0] dur);
        logic [7:0] tail [TRAILER_LEN];
        if (w.operation == OP_SEND)
        begin
            queue_frame(w.character, dur, 1'b1);
            if (w.character != CH_DOLLAR)
                crc_q = crc_update(crc_q, w.character);
        end
        else
        begin
            tail[0] = CH_STAR;
            tail[1] = hex_ascii(crc_q[15:12]);
            tail[2] = hex_ascii(crc_q[11:8]);
            tail[3] = hex_ascii(crc_q[7:4]);
            tail[4] = hex_ascii(crc_q[3:0]);
            tail[5] = CH_CR;
            tail[6] = CH_LF;
            for (int i = 0; i < TRAILER_LEN; i++)
                queue_frame(tail[i], dur, i == TRAILER_LEN - 1);
            crc_q = CRC_INIT;
        end
    endtask

    // present one word after a random gap and hold it until taken
    task automatic put_word(input op_t op, input logic [7:0] ch, input logic [DUR_W-1:0] dur);
        int       gap;
        in_word_t w;
        gap         = pick_gap();
        w.operation = op;
        w.character = ch;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        predict_word(w, (dur != '0) ? dur : hold_time(baud_q));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // baud write once the transmitter has drained
    task automatic set_baud(input logic [BAUD_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        baud_q    = v;
    endtask

    // output check against the oldest expected symbol
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected output word: level %0d duration_us %0d last %0d",
                       out_data.level, out_data.duration_us, out_data.last);
                mismatch_cnt++;
            end
            else
            begin
                e = pending_symbols.pop_front();
                if (out_data.level !== e.level)
                begin
                    $error("level: expected %0d, actual %0d", e.level, out_data.level);
                    mismatch_cnt++;
                end
                if (out_data.duration_us !== e.duration_us)
                begin
                    $error("duration_us: expected %0d, actual %0d",
                           e.duration_us, out_data.duration_us);
                    mismatch_cnt++;
                end
                if (out_data.last !== e.last)
                begin
                    $error("last: expected %0d, actual %0d", e.last, out_data.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver back-pressure
    initial
    begin
        out_ready  = 1'b0;
        ready_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
            begin
                out_ready  <= 1'b0;
                ready_hold = ready_hold - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_hold = pick_gap();
            end
        end
    end

    // run watchdog
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > CYCLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        logic [BAUD_W-1:0] b;
        int                r;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        mismatch_cnt = 0;
        baud_q       = BAUD_RESET;
        crc_q        = CRC_INIT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            if (PLAN[i].wr)
                set_baud(PLAN[i].baud);
            put_word(PLAN[i].op, PLAN[i].ch, PLAN[i].dur);
        end

        // random phases, one baud setting each
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       b = BAUD_300;
                1:       b = 10'd1023;
                2:       b = BAUD_100;
                3:       b = 10'd0;
                4:       b = ($urandom_range(0, 1) == 0) ? BAUD_150 : BAUD_200;
                default: b = 10'($urandom_range(0, 1023));
            endcase
            set_baud(b);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                r = $urandom_range(0, 15);
                if (r < 2)
                    put_word(OP_FINISH, 8'($urandom_range(0, 255)), '0);
                else if (r == 2)
                    put_word(OP_SEND, CH_DOLLAR, '0);
                else
                    put_word(OP_SEND, 8'($urandom_range(0, 255)), '0);
            end
        end
        in_valid <= 1'b0;

        // drain and let any stray word show up
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> rtty_telemetry_transmitter_crc16.f
+incdir+src
src/rttx_pkg.sv
src/rttx_front.sv
src/rttx_fifo.sv
src/rttx_back.sv
src/rtty_telemetry_transmitter_crc16.sv
dv/tb_rtty_telemetry_transmitter_crc16.sv
